@@ rtl/mfdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mfdc_pkg
// Constants shared by the fingerprint dedup cache: FNV-1a parameters, the
// reset value of the window register and the request op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mfdc_pkg;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned TICK_W = 32;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned OP_W   = 2;
   localparam int unsigned SLOT_OUT_W = 3;

   localparam logic [HASH_W-1:0] FNV_BASIS    = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME    = 32'd16777619;
   localparam logic [TICK_W-1:0] WINDOW_RESET = 32'd600000;

   localparam logic [OP_W-1:0] OP_ABSORB = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
   localparam logic [OP_W-1:0] OP_RECORD = 2'd2;

endpackage

`default_nettype wire

@@ rtl/mfdc_req_if.sv @@
// ----------------------------------------------------------------------------
// mfdc_req_if
// Request channel: one beat carries an op, a message byte and the tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfdc_req_if;
   import mfdc_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [BYTE_W-1:0]   data_byte;
   logic [TICK_W-1:0]   now_tick;

   modport source (output valid, output op, output data_byte, output now_tick,
                   input ready);
   modport sink   (input valid, input op, input data_byte, input now_tick,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/mfdc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mfdc_rsp_if
// Response channel: one beat per check, with the hit flag, slot and hash.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfdc_rsp_if;
   import mfdc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  is_duplicate;
   logic [SLOT_OUT_W-1:0] hit_slot;
   logic [HASH_W-1:0]     fingerprint;

   modport source (output valid, output is_duplicate, output hit_slot,
                   output fingerprint, input ready);
   modport sink   (input valid, input is_duplicate, input hit_slot,
                   input fingerprint, output ready);
endinterface

`default_nettype wire

@@ rtl/mfdc_slot_mem.sv @@
// ----------------------------------------------------------------------------
// mfdc_slot_mem
// Fingerprint cache storage: hash and tick per slot, one write port with
// separate hash and tick enables, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mfdc_slot_mem #(
   parameter int unsigned SLOTS = 8,
   parameter int unsigned IDX_W = 3
) (
   input  wire logic                        clock,
   input  wire logic                        wr_hash_en,
   input  wire logic                        wr_tick_en,
   input  wire logic [IDX_W-1:0]            wr_addr,
   input  wire logic [mfdc_pkg::HASH_W-1:0] wr_hash,
   input  wire logic [mfdc_pkg::TICK_W-1:0] wr_tick,
   input  wire logic [IDX_W-1:0]            rd_addr,
   output logic      [mfdc_pkg::HASH_W-1:0] rd_hash_ff,
   output logic      [mfdc_pkg::TICK_W-1:0] rd_tick_ff
);
   import mfdc_pkg::*;

   logic [HASH_W-1:0] hash_mem [SLOTS];
   logic [TICK_W-1:0] tick_mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_hash_en) begin
         hash_mem[wr_addr] <= wr_hash;
      end
      if (wr_tick_en) begin
         tick_mem[wr_addr] <= wr_tick;
      end
      rd_hash_ff <= hash_mem[rd_addr];
      rd_tick_ff <= tick_mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/message_fingerprint_dedup_cache_top.sv @@
// ----------------------------------------------------------------------------
// message_fingerprint_dedup_cache_top
// Duplicate-message filter: FNV-1a 32-bit hash over message bytes and a
// round-robin cache of recent fingerprints with an age window.
//
// req_bus beats: absorb folds data_byte into the running hash; check ends
// the message, latches its fingerprint, restarts the hash and scans the
// slots in index order; record stores the latched fingerprint and now_tick
// in the next round-robin slot. Only check returns a beat on rsp_bus.
// csr_wr_en/csr_wr_data write window_ticks; write only while idle.
// Timing: one request at a time. Absorb, record and unused ops go through
// one execute state. A check then scans slot by slot (read, then compare
// through the one compare unit) before the response is registered.
// The scan stops at the first hit.
// The response sits in an output register; a new request is taken while it
// waits, but a further check holds at its end until rsp_bus is free.
// Reset (synchronous) clears all slot valid bits, the slot pointer and the
// latched fingerprint, sets the hash to the FNV-1a basis and window_ticks to 600000.
// ----------------------------------------------------------------------------
`default_nettype none

module message_fingerprint_dedup_cache_top #(
   parameter int unsigned SLOTS = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   mfdc_req_if.sink                         req_bus,
   mfdc_rsp_if.source                       rsp_bus,
   input  wire logic                        csr_wr_en,
   input  wire logic [mfdc_pkg::TICK_W-1:0] csr_wr_data
);
   import mfdc_pkg::*;

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RD,
      S_CMP,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [TICK_W-1:0]     window_ff, window_in;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [HASH_W-1:0]     latched_ff, latched_in;
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic [IDX_W-1:0]      next_slot_ff, next_slot_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic                  hit_ff, hit_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic [TICK_W-1:0]     now_ff, now_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_dup_ff, rsp_dup_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [HASH_W-1:0]     rsp_fp_ff, rsp_fp_in;

   logic              wr_hash_en;
   logic              wr_tick_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [HASH_W-1:0] rd_hash;
   logic [TICK_W-1:0] rd_tick;
   logic [HASH_W-1:0] mix;
   logic [TICK_W-1:0] age;
   logic              match;
   logic              req_fire;

   mfdc_slot_mem #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_slot_mem (
      .clock      (clock),
      .wr_hash_en (wr_hash_en),
      .wr_tick_en (wr_tick_en),
      .wr_addr    (wr_addr),
      .wr_hash    (latched_ff),
      .wr_tick    (now_ff),
      .rd_addr    (scan_ff),
      .rd_hash_ff (rd_hash),
      .rd_tick_ff (rd_tick)
   );

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign req_fire             = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.is_duplicate = rsp_dup_ff;
   assign rsp_bus.hit_slot     = rsp_slot_ff;
   assign rsp_bus.fingerprint  = rsp_fp_ff;

   assign mix   = hash_ff ^ {{(HASH_W-BYTE_W){1'b0}}, byte_ff};
   assign age   = now_ff - rd_tick;
   assign match = valid_ff[scan_ff] && (rd_hash == latched_ff) && (age < window_ff);

   always_comb begin
      state_in     = state_ff;
      window_in    = csr_wr_en ? csr_wr_data : window_ff;
      hash_in      = hash_ff;
      latched_in   = latched_ff;
      valid_in     = valid_ff;
      next_slot_in = next_slot_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      op_in        = op_ff;
      byte_in      = byte_ff;
      now_in       = now_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_dup_in   = rsp_dup_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_fp_in    = rsp_fp_ff;
      wr_hash_en   = 1'b0;
      wr_tick_en   = 1'b0;
      wr_addr      = next_slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_bus.op;
               byte_in  = req_bus.data_byte;
               now_in   = req_bus.now_tick;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (op_ff)
               OP_ABSORB: begin
                  hash_in = mix * FNV_PRIME;
               end
               OP_CHECK: begin
                  latched_in = hash_ff;
                  hash_in    = FNV_BASIS;
                  scan_in    = '0;
                  hit_in     = 1'b0;
                  state_in   = S_RD;
               end
               OP_RECORD: begin
                  wr_hash_en             = 1'b1;
                  wr_tick_en             = 1'b1;
                  valid_in[next_slot_ff] = 1'b1;
                  next_slot_in = (next_slot_ff == LAST_IDX) ? '0 : next_slot_ff + IDX_ONE;
               end
               default: begin
               end
            endcase
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (match) begin
               wr_tick_en = 1'b1;
               wr_addr    = scan_ff;
               hit_in     = 1'b1;
               state_in   = S_DONE;
            end else if (scan_ff == LAST_IDX) begin
               state_in = S_DONE;
            end else begin
               scan_in  = scan_ff + IDX_ONE;
               state_in = S_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_dup_in   = hit_ff;
               rsp_slot_in  = hit_ff ? SLOT_OUT_W'(scan_ff) : '0;
               rsp_fp_in    = latched_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WINDOW_RESET;
         hash_ff      <= FNV_BASIS;
         latched_ff   <= '0;
         valid_ff     <= '0;
         next_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         hash_ff      <= hash_in;
         latched_ff   <= latched_in;
         valid_ff     <= valid_in;
         next_slot_ff <= next_slot_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         hit_ff       <= hit_in;
         op_ff        <= op_in;
         byte_ff      <= byte_in;
         now_ff       <= now_in;
         rsp_dup_ff   <= rsp_dup_in;
         rsp_slot_ff  <= rsp_slot_in;
         rsp_fp_ff    <= rsp_fp_in;
      end
   end

endmodule

`default_nettype wire

@@ sim/tb_message_fingerprint_dedup_cache_top.sv @@
// ----------------------------------------------------------------------------
// tb_message_fingerprint_dedup_cache_top
// Self-checking bench for the fingerprint dedup cache. A scoreboard class
// predicts each check beat (FNV-1a hash, slot scan with age window, round
// robin record) and matches it against rsp_bus. Stimulus is a short directed
// run followed by messages drawn from a small pool so that fingerprints
// repeat, mixed with cut-off messages and random beats, under several window
// settings, with random gaps on the request side and stalls on the response
// side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_message_fingerprint_dedup_cache_top;
   import mfdc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SLOTS           = 8;
   localparam int          CHECK_CYCLES    = 2 + 2 * SLOTS;
   localparam int          SETTLE_CYCLES   = CHECK_CYCLES + 6;
   localparam int          POOL_SIZE       = 10;
   localparam int          ITEMS_PER_PHASE = 160;
   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

   typedef struct packed {
      logic                  dup;
      logic [SLOT_OUT_W-1:0] slot;
      logic [HASH_W-1:0]     fp;
   } verdict_type;

   class dedup_cache_model;
      logic [TICK_W-1:0] window;
      logic [HASH_W-1:0] running_hash;
      logic [HASH_W-1:0] latched_fp;
      logic [HASH_W-1:0] slot_hash [SLOTS];
      logic [TICK_W-1:0] slot_tick [SLOTS];
      bit                slot_valid [SLOTS];
      int unsigned       next_slot;
      verdict_type       expected_verdicts [$];
      int                failures;
      int                verdict_count;
      int                duplicate_count;

      function new();
         window       = WINDOW_RESET;
         running_hash = FNV_BASIS;
         latched_fp   = '0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_hash[i]  = '0;
            slot_tick[i]  = '0;
            slot_valid[i] = 1'b0;
         end
         next_slot       = 0;
         failures        = 0;
         verdict_count   = 0;
         duplicate_count = 0;
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                 logic [TICK_W-1:0] tick);
         verdict_type       v;
         logic [TICK_W-1:0] age;
         case (op)
            OP_ABSORB: begin
               running_hash = (running_hash ^ HASH_W'(data)) * FNV_PRIME;
            end
            OP_CHECK: begin
               v    = '0;
               v.fp = running_hash;
               for (int i = 0; i < SLOTS; i++) begin
                  age = tick - slot_tick[i];
                  if (!v.dup && slot_valid[i] && slot_hash[i] == running_hash &&
                      age < window) begin
                     slot_tick[i] = tick;
                     v.dup        = 1'b1;
                     v.slot       = SLOT_OUT_W'(i);
                  end
               end
               latched_fp   = running_hash;
               running_hash = FNV_BASIS;
               expected_verdicts.push_back(v);
            end
            OP_RECORD: begin
               slot_hash[next_slot]  = latched_fp;
               slot_tick[next_slot]  = tick;
               slot_valid[next_slot] = 1'b1;
               next_slot             = (next_slot + 1) % SLOTS;
            end
            default: begin
            end
         endcase
      endfunction

      function void check_verdict(logic dup, logic [SLOT_OUT_W-1:0] slot,
                                  logic [HASH_W-1:0] fp);
         verdict_type exp_v;
         if (expected_verdicts.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: response beat with nothing pending (dup=%0b slot=%0d fp=%h)",
                        dup, slot, fp);
            return;
         end
         exp_v = expected_verdicts.pop_front();
         verdict_count++;
         if (exp_v.dup)
            duplicate_count++;
         if (dup !== exp_v.dup || slot !== exp_v.slot || fp !== exp_v.fp) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: check %0d expected dup=%0b slot=%0d fp=%h, got dup=%0b slot=%0d fp=%h",
                        verdict_count, exp_v.dup, exp_v.slot, exp_v.fp, dup, slot, fp);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [TICK_W-1:0] csr_wr_data;

   mfdc_req_if req_bus ();
   mfdc_rsp_if rsp_bus ();

   message_fingerprint_dedup_cache_top #(
      .SLOTS (SLOTS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dedup_cache_model  model = new();
   logic [BYTE_W-1:0] msg_pool [POOL_SIZE][$];
   logic [TICK_W-1:0] tick_now;
   logic [TICK_W-1:0] window_cur;
   int                items_sent;
   int                window_writes;
   bit                no_gap_mode;
   bit                rx_steady;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response side: random stalls, with occasional stretches of steady ready
   initial begin
      int stall_left;
      stall_left = 0;
      rx_steady = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            model.check_verdict(rsp_bus.is_duplicate, rsp_bus.hit_slot, rsp_bus.fingerprint);
         if ($urandom_range(0, 199) == 0)
            rx_steady = !rx_steady;
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                               input logic [TICK_W-1:0] tick);
      int gap;
      gap = no_gap_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.data_byte <= data;
      req_bus.now_tick  <= tick;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      model.note_request(op, data, tick);
      if (op != OP_UNUSED)
         items_sent++;
   endtask

   task automatic write_window(input logic [TICK_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      model.window = value;
      window_cur   = value;
      window_writes++;
   endtask

   function automatic void advance_tick();
      int                r;
      logic [TICK_W-1:0] span;
      span = (window_cur / 4 > 32'd1_000_000) ? 32'd1_000_000 : window_cur / 4 + 1;
      r = $urandom_range(0, 9);
      if (r < 6)
         tick_now = tick_now + $urandom_range(0, span);
      else if (r < 8)
         tick_now = tick_now + window_cur - 1 + $urandom_range(0, 2);
      else if (r == 8)
         tick_now = tick_now + $urandom;
   endfunction

   // sender id digits, a comma, then arbitrary content bytes
   function automatic void build_pool();
      int n;
      for (int k = 0; k < POOL_SIZE; k++) begin
         msg_pool[k].delete();
         if (k == 0 && $urandom_range(0, 2) == 0)
            continue;
         n = $urandom_range(1, 11);
         for (int j = 0; j < n; j++)
            msg_pool[k].push_back(8'h30 + BYTE_W'($urandom_range(0, 9)));
         msg_pool[k].push_back(8'h2C);
         n = $urandom_range(0, 10);
         for (int j = 0; j < n; j++)
            msg_pool[k].push_back(BYTE_W'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_message(input int idx, input int n_bytes, input bit with_record);
      for (int j = 0; j < n_bytes && j < msg_pool[idx].size(); j++)
         send_request(OP_ABSORB, msg_pool[idx][j], $urandom);
      advance_tick();
      send_request(OP_CHECK, BYTE_W'($urandom_range(0, 255)), tick_now);
      if (with_record) begin
         if ($urandom_range(0, 3) == 0)
            advance_tick();
         send_request(OP_RECORD, BYTE_W'($urandom_range(0, 255)), tick_now);
      end
   endtask

   task automatic run_random(input int budget);
      int stop_at;
      int r;
      int idx;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 29) == 0)
            no_gap_mode = !no_gap_mode;
         r   = $urandom_range(0, 99);
         idx = $urandom_range(0, POOL_SIZE - 1);
         if (r < 80)
            send_message(idx, msg_pool[idx].size(), $urandom_range(0, 9) < 7);
         else if (r < 88)
            send_message(idx, $urandom_range(0, msg_pool[idx].size()),
                         $urandom_range(0, 1) == 1);
         else
            send_request(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                         $urandom);
      end
   endtask

   initial begin
      logic [TICK_W-1:0] phase_windows [7];
      logic [BYTE_W-1:0] fixed_msg [3];

      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.op        <= OP_ABSORB;
      req_bus.data_byte <= '0;
      req_bus.now_tick  <= '0;
      items_sent    = 0;
      window_writes = 0;
      no_gap_mode   = 1'b0;
      window_cur    = WINDOW_RESET;
      fixed_msg     = '{8'h00, 8'hFF, 8'h2C};
      phase_windows = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd40, 32'd5000, $urandom,
                        WINDOW_RESET};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: unused op, record before any check, empty message,
      // hit inside the window, miss at exactly the window, hit across wrap
      send_request(OP_UNUSED, 8'hA5, 32'hFFFF_FFFF);
      send_request(OP_RECORD, 8'h00, 32'd0);
      send_request(OP_CHECK, 8'h00, 32'd0);
      foreach (fixed_msg[j]) send_request(OP_ABSORB, fixed_msg[j], 32'd0);
      send_request(OP_CHECK, 8'h00, 32'd100);
      send_request(OP_RECORD, 8'h00, 32'd100);
      foreach (fixed_msg[j]) send_request(OP_ABSORB, fixed_msg[j], 32'hFFFF_FFFF);
      send_request(OP_CHECK, 8'h00, 32'd100 + WINDOW_RESET - 1);
      foreach (fixed_msg[j]) send_request(OP_ABSORB, fixed_msg[j], 32'd0);
      send_request(OP_CHECK, 8'h00, 32'd99 + 2 * WINDOW_RESET);
      send_request(OP_RECORD, 8'h00, 32'hFFFF_FFF0);
      foreach (fixed_msg[j]) send_request(OP_ABSORB, fixed_msg[j], 32'd0);
      send_request(OP_CHECK, 8'hFF, 32'h0000_0010);

      tick_now = 32'd0;
      build_pool();
      run_random(ITEMS_PER_PHASE);
      foreach (phase_windows[p]) begin
         write_window(phase_windows[p]);
         tick_now = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 4000);
         build_pool();
         run_random(ITEMS_PER_PHASE);
      end

      req_bus.valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (model.pending() != 0)
         $display("mismatch: %0d expected responses never arrived", model.pending());
      $display("summary: %0d request beats under %0d written window values",
               items_sent, window_writes);
      $display("summary: %0d fingerprints checked, %0d reported as duplicates",
               model.verdict_count, model.duplicate_count);
      if (model.failures == 0 && model.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
